// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define COBB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define COBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("assertion failed");
`else
`define COBB_ASSERT(lbl, clk, rst_n, prop)
`define COBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cobb_pkg.sv =====
// shared constants and the cordic arctangent table
package cobb_pkg;
	localparam int CORDIC_W   = 32;
	localparam int TRIG_W     = 30;
	localparam int FRAC       = 28;
	localparam int QUO_W      = FRAC + 1;
	localparam int NORM_W     = 16;
	localparam int NORM_FRAC  = 14;
	localparam int NORM_SHIFT = 2 * FRAC - NORM_FRAC;
	localparam int NORM_ONE   = 16384;
	localparam int ATAN_STEPS = 24;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [CORDIC_W-1:0] TRIG_ONE30  = 32'sh4000_0000;

	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// ===== rtl/cobb_in_if.sv =====
// input channel: one circle and one rotated box per item
interface cobb_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] circle_x;
	logic signed [COORD_WIDTH-1:0] circle_y;
	logic [COORD_WIDTH-2:0]        circle_radius;
	logic signed [COORD_WIDTH-1:0] box_x;
	logic signed [COORD_WIDTH-1:0] box_y;
	logic [COORD_WIDTH-2:0]        box_width;
	logic [COORD_WIDTH-2:0]        box_height;
	logic [ANGLE_WIDTH-1:0]        box_angle;

	modport source(output valid, circle_x, circle_y, circle_radius, box_x, box_y,
		box_width, box_height, box_angle, input ready);
	modport sink(input valid, circle_x, circle_y, circle_radius, box_x, box_y,
		box_width, box_height, box_angle, output ready);
endinterface

// ===== rtl/cobb_out_if.sv =====
// output channel: one contact result per item
interface cobb_out_if #(
	parameter int COORD_WIDTH = 32
) ();
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [COORD_WIDTH-2:0]        depth;
	logic signed [COORD_WIDTH-1:0] contact_x;
	logic signed [COORD_WIDTH-1:0] contact_y;
	logic signed [15:0]            normal_x;
	logic signed [15:0]            normal_y;

	modport source(output valid, hit, depth, contact_x, contact_y, normal_x, normal_y,
		input ready);
	modport sink(input valid, hit, depth, contact_x, contact_y, normal_x, normal_y,
		output ready);
endinterface

// ===== rtl/cobb_cordic.sv =====
// pipelined rotation-mode cordic giving cosine and sine of a binary angle
module cobb_cordic #(
	parameter int ANGLE_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16,
	parameter int SIDE_W       = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [ANGLE_WIDTH-1:0]                 angle,
	input  logic [SIDE_W-1:0]                      side_in,
	output logic                                   out_valid,
	output logic signed [cobb_pkg::TRIG_W-1:0]     cos_out,
	output logic signed [cobb_pkg::TRIG_W-1:0]     sin_out,
	output logic [SIDE_W-1:0]                      side_out
);
	localparam int CW = cobb_pkg::CORDIC_W;
	localparam int TW = cobb_pkg::TRIG_W;
	localparam int NS = CORDIC_STEPS;

	logic signed [CW-1:0] x_s [0:NS];
	logic signed [CW-1:0] y_s [0:NS];
	logic signed [CW-1:0] z_s [0:NS];
	logic [1:0]           q_s [0:NS];
	logic                 v_s [0:NS];
	logic [SIDE_W-1:0]    side_s [0:NS];

	logic [31:0]          a32;
	logic [31:0]          u;
	logic signed [CW-1:0] z0;

	// offset by an eighth turn so the residual angle stays within +-45 degrees
	assign a32 = 32'(angle) << (32 - ANGLE_WIDTH);
	assign u   = a32 + 32'h2000_0000;
	assign z0  = $signed(CW'(u[29:0])) - 32'sh2000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= cobb_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= z0;
			q_s[0]    <= u[31:30];
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_iter
		logic signed [CW-1:0] at;
		assign at = $signed(cobb_pkg::atan_turn(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - at;
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + at;
				end
				q_s[k+1]    <= q_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	logic signed [CW-1:0] xr, yr, xc, yc, xh, yh;

	// quadrant fold, clamp to one, round Q1.30 down to Q1.28
	always_comb begin
		case (q_s[NS])
			2'd1: begin
				xr = -y_s[NS];
				yr = x_s[NS];
			end
			2'd2: begin
				xr = -x_s[NS];
				yr = -y_s[NS];
			end
			2'd3: begin
				xr = y_s[NS];
				yr = -x_s[NS];
			end
			default: begin
				xr = x_s[NS];
				yr = y_s[NS];
			end
		endcase
		xc = (xr > cobb_pkg::TRIG_ONE30) ? cobb_pkg::TRIG_ONE30 :
			(xr < -cobb_pkg::TRIG_ONE30) ? -cobb_pkg::TRIG_ONE30 : xr;
		yc = (yr > cobb_pkg::TRIG_ONE30) ? cobb_pkg::TRIG_ONE30 :
			(yr < -cobb_pkg::TRIG_ONE30) ? -cobb_pkg::TRIG_ONE30 : yr;
		xh = (xc + 32'sd2) >>> 2;
		yh = (yc + 32'sd2) >>> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out  <= TW'(xh);
			sin_out  <= TW'(yh);
			side_out <= side_s[NS];
		end
	end
endmodule

// ===== rtl/cobb_isqrt.sv =====
// pipelined integer square root, one result bit per stage, rounded to nearest
module cobb_isqrt #(
	parameter int OUT_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2*OUT_W-1:0]   radicand,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     root,
	output logic [SIDE_W-1:0]    side_out
);
	localparam int IN_W  = 2 * OUT_W;
	localparam int REM_W = OUT_W + 2;

	logic [IN_W-1:0]   src_s  [0:OUT_W];
	logic [REM_W-1:0]  rem_s  [0:OUT_W];
	logic [OUT_W-1:0]  rt_s   [0:OUT_W];
	logic              v_s    [0:OUT_W];
	logic [SIDE_W-1:0] side_s [0:OUT_W];

	assign src_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign rt_s[0]   = '0;
	assign v_s[0]    = in_valid;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < OUT_W; k++) begin : g_step
		logic [REM_W-1:0] acc, trial;
		assign acc   = {rem_s[k][OUT_W-1:0], src_s[k][IN_W-1 -: 2]};
		assign trial = {rt_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= trial) begin
					rem_s[k+1] <= acc - trial;
					rt_s[k+1]  <= {rt_s[k][OUT_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= acc;
					rt_s[k+1]  <= {rt_s[k][OUT_W-2:0], 1'b0};
				end
				src_s[k+1]  <= src_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[OUT_W];
		end
	end

	// remainder above the floor root means the true root is past the half
	always_ff @(posedge clk) begin
		if (en) begin
			root     <= (rem_s[OUT_W] > REM_W'(rt_s[OUT_W])) ? rt_s[OUT_W] + 1'b1 : rt_s[OUT_W];
			side_out <= side_s[OUT_W];
		end
	end
endmodule

// ===== rtl/cobb_div2.sv =====
// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
module cobb_div2 #(
	parameter int DEN_W  = 32,
	parameter int QUO_W  = 29,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [DEN_W+QUO_W-1:0]   num_a,
	input  logic [DEN_W+QUO_W-1:0]   num_b,
	input  logic [DEN_W-1:0]         den,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output logic [QUO_W-1:0]         quo_a,
	output logic [QUO_W-1:0]         quo_b,
	output logic [SIDE_W-1:0]        side_out
);
	// the upper DEN_W bits of each numerator are below den, so the quotient fits
	logic [DEN_W-1:0]  ra_s   [0:QUO_W];
	logic [DEN_W-1:0]  rb_s   [0:QUO_W];
	logic [QUO_W-1:0]  qa_s   [0:QUO_W];
	logic [QUO_W-1:0]  qb_s   [0:QUO_W];
	logic [DEN_W-1:0]  d_s    [0:QUO_W];
	logic              v_s    [0:QUO_W];
	logic [SIDE_W-1:0] side_s [0:QUO_W];

	assign ra_s[0]   = num_a[DEN_W+QUO_W-1 -: DEN_W];
	assign rb_s[0]   = num_b[DEN_W+QUO_W-1 -: DEN_W];
	assign qa_s[0]   = num_a[QUO_W-1:0];
	assign qb_s[0]   = num_b[QUO_W-1:0];
	assign d_s[0]    = den;
	assign v_s[0]    = in_valid;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] sha, shb;
		logic           gea, geb;
		assign sha = {ra_s[k], qa_s[k][QUO_W-1]};
		assign shb = {rb_s[k], qb_s[k][QUO_W-1]};
		assign gea = sha >= {1'b0, d_s[k]};
		assign geb = shb >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k+1]   <= DEN_W'(gea ? sha - {1'b0, d_s[k]} : sha);
				rb_s[k+1]   <= DEN_W'(geb ? shb - {1'b0, d_s[k]} : shb);
				qa_s[k+1]   <= {qa_s[k][QUO_W-2:0], gea};
				qb_s[k+1]   <= {qb_s[k][QUO_W-2:0], geb};
				d_s[k+1]    <= d_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quo_a     = qa_s[QUO_W];
	assign quo_b     = qb_s[QUO_W];
	assign side_out  = side_s[QUO_W];
endmodule

// ===== rtl/circle_obb_collision.sv =====
// top level: circle against oriented box contact pipeline
// Accepts one circle/box pair per clock while not halted and returns one
// result per pair, in order. Its path runs through the cordic stages, the
// box-frame geometry stages, one square-root stage per distance bit, one
// divider stage per normal quotient bit and the normal stages. A two-entry
// output buffer keeps the input ready while a finished result waits; the
// pipeline halts only when both entries are full. Coordinates are Q16.16,
// the normal Q1.14; results of a miss are all zero.
`include "assert_macros.svh"
module circle_obb_collision #(
	parameter int COORD_WIDTH  = 32,
	parameter int ANGLE_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input logic       clk,
	input logic       arst_n,
	cobb_in_if.sink   in_ch,
	cobb_out_if.source out_ch
);
	localparam int WW   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam int TW   = cobb_pkg::TRIG_W;
	localparam int FR   = cobb_pkg::FRAC;
	localparam int QW   = cobb_pkg::QUO_W;
	localparam int NW   = cobb_pkg::NORM_W;
	localparam int OW   = WW + 1;
	localparam int LW   = WW + 2;
	localparam int DW   = LW + 1;
	localparam int PW   = OW + TW;
	localparam int SW   = PW + 1;
	localparam int CPW  = WW + TW;
	localparam int CSW  = CPW + 1;
	localparam int NPW  = 2 * TW;
	localparam int NSW  = NPW + 1;
	localparam int NRW  = NSW - cobb_pkg::NORM_SHIFT;

	localparam logic signed [SW-1:0]  HALF_L = SW'(1) <<< (FR - 1);
	localparam logic signed [CSW-1:0] HALF_C = CSW'(1) <<< (FR - 1);
	localparam logic signed [NSW-1:0] HALF_N = NSW'(1) <<< (cobb_pkg::NORM_SHIFT - 1);
	localparam logic signed [TW:0]    HALF_T = (TW+1)'(1) <<< (FR - cobb_pkg::NORM_FRAC - 1);
	localparam logic signed [NRW-1:0] N_ONE  = NRW'(cobb_pkg::NORM_ONE);
	localparam logic signed [NW-1:0]  N_ONEW = NW'(cobb_pkg::NORM_ONE);

	typedef struct packed {
		logic signed [OW-1:0] ox;
		logic signed [OW-1:0] oy;
		logic [WW-2:0]        rad;
		logic [WW-3:0]        hw;
		logic [WW-3:0]        hh;
		logic signed [WW-1:0] bx;
		logic signed [WW-1:0] by;
	} geo_t;

	typedef struct packed {
		logic                 hit;
		logic [WW-2:0]        rad;
		logic signed [WW-1:0] wx;
		logic signed [WW-1:0] wy;
		logic signed [WW-1:0] dx;
		logic signed [WW-1:0] dy;
		logic                 d2zero;
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} sq_t;

	typedef struct packed {
		logic                 hit;
		logic [WW-2:0]        depth;
		logic signed [WW-1:0] wx;
		logic signed [WW-1:0] wy;
		logic                 negx;
		logic                 negy;
		logic                 d2zero;
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} dv_t;

	typedef struct packed {
		logic                          hit;
		logic [COORD_WIDTH-2:0]        depth;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [NW-1:0]          nx;
		logic signed [NW-1:0]          ny;
	} res_t;

	logic en;

	// input conditioning and the box-relative offset
	geo_t                 geo_in;
	logic signed [WW-1:0] cx_in, cy_in;

	assign cx_in         = in_ch.circle_x[WW-1:0];
	assign cy_in         = in_ch.circle_y[WW-1:0];
	assign geo_in.bx     = in_ch.box_x[WW-1:0];
	assign geo_in.by     = in_ch.box_y[WW-1:0];
	assign geo_in.ox     = OW'(cx_in) - OW'(geo_in.bx);
	assign geo_in.oy     = OW'(cy_in) - OW'(geo_in.by);
	assign geo_in.rad    = in_ch.circle_radius[WW-2:0];
	assign geo_in.hw     = in_ch.box_width[WW-2:1];
	assign geo_in.hh     = in_ch.box_height[WW-2:1];
	assign in_ch.ready   = en;

	logic                 v_c;
	logic signed [TW-1:0] c_c, s_c;
	logic [$bits(geo_t)-1:0] geo_cv;

	cobb_cordic #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS),
		.SIDE_W      ($bits(geo_t))
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.angle    (in_ch.box_angle),
		.side_in  (geo_in),
		.out_valid(v_c),
		.cos_out  (c_c),
		.sin_out  (s_c),
		.side_out (geo_cv)
	);

	geo_t geo_c;
	assign geo_c = geo_t'(geo_cv);

	// stage registers of the box-frame geometry
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	geo_t g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7;
	logic signed [TW-1:0] c_s1, s_s1, c_s2, s_s2, c_s3, s_s3, c_s4, s_s4;
	logic signed [TW-1:0] c_s5, s_s5, c_s6, s_s6, c_s7, s_s7;
	logic signed [PW-1:0] p_oxc_s1, p_oys_s1, p_oyc_s1, p_oxs_s1;
	logic signed [LW-1:0] lx_s2, ly_s2, lx_s3, ly_s3;
	logic signed [WW-1:0] clx_s3, cly_s3, clx_s4, cly_s4;
	logic signed [WW-1:0] dx_s4, dy_s4, dx_s5, dy_s5, dx_s6, dy_s6, dx_s7, dy_s7;
	logic                 near_s4, near_s5, near_s6;
	logic signed [2*WW-1:0] dxx_s5, dyy_s5;
	logic [2*WW-3:0]        rr_s5, rr_s6;
	logic signed [CPW-1:0]  pcc_s5, pss_s5, pcs_s5, psc_s5;
	logic [2*WW-1:0]        d2_s6, d2_s7;
	logic signed [WW-1:0]   tx_s6, ty_s6;
	logic                   hit_s7, d2zero_s7;
	logic signed [WW-1:0]   wx_s7, wy_s7;

	logic signed [SW-1:0]  lsx, lsy;
	logic signed [LW-1:0]  hwx, hhx, clxf, clyf;
	logic signed [DW-1:0]  dxf, dyf, radd;
	logic signed [CSW-1:0] tsx, tsy;
	logic signed [WW:0]    wsx, wsy;
	logic signed [WW-1:0]  wmax, wmin;

	always_comb begin
		lsx  = SW'(p_oxc_s1) + SW'(p_oys_s1) + HALF_L;
		lsy  = SW'(p_oyc_s1) - SW'(p_oxs_s1) + HALF_L;
		hwx  = $signed(LW'(g_s2.hw));
		hhx  = $signed(LW'(g_s2.hh));
		clxf = (lx_s2 > hwx) ? hwx : ((lx_s2 < -hwx) ? -hwx : lx_s2);
		clyf = (ly_s2 > hhx) ? hhx : ((ly_s2 < -hhx) ? -hhx : ly_s2);
		dxf  = DW'(lx_s3) - DW'(clx_s3);
		dyf  = DW'(ly_s3) - DW'(cly_s3);
		radd = $signed(DW'(g_s3.rad));
		tsx  = CSW'(pcc_s5) - CSW'(pss_s5) + HALF_C;
		tsy  = CSW'(pcs_s5) + CSW'(psc_s5) + HALF_C;
		wsx  = (WW+1)'(g_s6.bx) + (WW+1)'(tx_s6);
		wsy  = (WW+1)'(g_s6.by) + (WW+1)'(ty_s6);
		wmax = {1'b0, {(WW-1){1'b1}}};
		wmin = {1'b1, {(WW-1){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_c;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// rotate the offset into the box frame
			g_s1     <= geo_c;
			c_s1     <= c_c;
			s_s1     <= s_c;
			p_oxc_s1 <= geo_c.ox * c_c;
			p_oys_s1 <= geo_c.oy * s_c;
			p_oyc_s1 <= geo_c.oy * c_c;
			p_oxs_s1 <= geo_c.ox * s_c;

			g_s2  <= g_s1;
			c_s2  <= c_s1;
			s_s2  <= s_s1;
			lx_s2 <= LW'(lsx >>> FR);
			ly_s2 <= LW'(lsy >>> FR);

			// closest point on the box
			g_s3   <= g_s2;
			c_s3   <= c_s2;
			s_s3   <= s_s2;
			lx_s3  <= lx_s2;
			ly_s3  <= ly_s2;
			clx_s3 <= WW'(clxf);
			cly_s3 <= WW'(clyf);

			// a component beyond the radius is a miss before any squaring
			g_s4    <= g_s3;
			c_s4    <= c_s3;
			s_s4    <= s_s3;
			clx_s4  <= clx_s3;
			cly_s4  <= cly_s3;
			dx_s4   <= WW'(dxf);
			dy_s4   <= WW'(dyf);
			near_s4 <= (dxf <= radd) && (dxf >= -radd) && (dyf <= radd) && (dyf >= -radd);

			g_s5    <= g_s4;
			c_s5    <= c_s4;
			s_s5    <= s_s4;
			dx_s5   <= dx_s4;
			dy_s5   <= dy_s4;
			near_s5 <= near_s4;
			dxx_s5  <= dx_s4 * dx_s4;
			dyy_s5  <= dy_s4 * dy_s4;
			rr_s5   <= g_s4.rad * g_s4.rad;
			pcc_s5  <= clx_s4 * c_s4;
			pss_s5  <= cly_s4 * s_s4;
			pcs_s5  <= clx_s4 * s_s4;
			psc_s5  <= cly_s4 * c_s4;

			g_s6    <= g_s5;
			c_s6    <= c_s5;
			s_s6    <= s_s5;
			dx_s6   <= dx_s5;
			dy_s6   <= dy_s5;
			near_s6 <= near_s5;
			rr_s6   <= rr_s5;
			d2_s6   <= $unsigned(dxx_s5) + $unsigned(dyy_s5);
			tx_s6   <= WW'(tsx >>> FR);
			ty_s6   <= WW'(tsy >>> FR);

			// back to world frame, saturated to the coordinate range
			g_s7      <= g_s6;
			c_s7      <= c_s6;
			s_s7      <= s_s6;
			dx_s7     <= dx_s6;
			dy_s7     <= dy_s6;
			d2_s7     <= d2_s6;
			hit_s7    <= near_s6 && (d2_s6 <= (2*WW)'(rr_s6));
			d2zero_s7 <= d2_s6 == '0;
			wx_s7     <= (wsx[WW] != wsx[WW-1]) ? (wsx[WW] ? wmin : wmax) : WW'(wsx);
			wy_s7     <= (wsy[WW] != wsy[WW-1]) ? (wsy[WW] ? wmin : wmax) : WW'(wsy);
		end
	end

	// distance
	sq_t sq_in, sq_out;
	logic [$bits(sq_t)-1:0] sq_outv;
	logic                   v_q;
	logic [WW-1:0]          dist_q;

	assign sq_in = '{hit: hit_s7, rad: g_s7.rad, wx: wx_s7, wy: wy_s7, dx: dx_s7, dy: dy_s7,
		d2zero: d2zero_s7, c: c_s7, s: s_s7};

	cobb_isqrt #(
		.OUT_W (WW),
		.SIDE_W($bits(sq_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.radicand (d2_s7),
		.side_in  (sq_in),
		.out_valid(v_q),
		.root     (dist_q),
		.side_out (sq_outv)
	);

	assign sq_out = sq_t'(sq_outv);

	// numerators for the normal: |d| scaled to Q.28 plus half the divisor
	logic                  v_s8;
	dv_t                   dv_s8;
	logic [WW+QW-1:0]      numx_s8, numy_s8;
	logic [WW-1:0]         den_s8;
	logic [WW-1:0]         mx, my;

	assign mx = sq_out.dx[WW-1] ? WW'(-sq_out.dx) : WW'(sq_out.dx);
	assign my = sq_out.dy[WW-1] ? WW'(-sq_out.dy) : WW'(sq_out.dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s8.hit    <= sq_out.hit;
			dv_s8.depth  <= sq_out.rad - dist_q[WW-2:0];
			dv_s8.wx     <= sq_out.wx;
			dv_s8.wy     <= sq_out.wy;
			dv_s8.negx   <= ~sq_out.dx[WW-1];
			dv_s8.negy   <= ~sq_out.dy[WW-1];
			dv_s8.d2zero <= sq_out.d2zero;
			dv_s8.c      <= sq_out.c;
			dv_s8.s      <= sq_out.s;
			numx_s8      <= (WW+QW)'({mx, {FR{1'b0}}}) + (WW+QW)'(dist_q >> 1);
			numy_s8      <= (WW+QW)'({my, {FR{1'b0}}}) + (WW+QW)'(dist_q >> 1);
			den_s8       <= dist_q;
		end
	end

	logic                 v_d;
	logic [QW-1:0]        qx_d, qy_d;
	logic [$bits(dv_t)-1:0] dv_dv;
	dv_t                  dv_d;

	cobb_div2 #(
		.DEN_W (WW),
		.QUO_W (QW),
		.SIDE_W($bits(dv_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num_a    (numx_s8),
		.num_b    (numy_s8),
		.den      (den_s8),
		.side_in  (dv_s8),
		.out_valid(v_d),
		.quo_a    (qx_d),
		.quo_b    (qy_d),
		.side_out (dv_dv)
	);

	assign dv_d = dv_t'(dv_dv);

	// signed unit vector, rotate to world, round to Q1.14
	logic                 v_s9, v_s10, v_s11;
	dv_t                  dv_s9, dv_s10;
	logic signed [TW-1:0] ux_s9, uy_s9;
	logic signed [NPW-1:0] nxc_s10, nys_s10, nxs_s10, nyc_s10;
	res_t                 res_s11;

	logic signed [NSW-1:0] nsx, nsy;
	logic signed [NRW-1:0] nrx, nry;
	logic signed [NW-1:0]  ncx, ncy, nfx, nfy;
	logic signed [TW:0]    tcx, tcy;

	always_comb begin
		nsx = NSW'(nxc_s10) - NSW'(nys_s10) + HALF_N;
		nsy = NSW'(nxs_s10) + NSW'(nyc_s10) + HALF_N;
		nrx = NRW'(nsx >>> cobb_pkg::NORM_SHIFT);
		nry = NRW'(nsy >>> cobb_pkg::NORM_SHIFT);
		ncx = (nrx > N_ONE) ? N_ONEW : ((nrx < -N_ONE) ? -N_ONEW : NW'(nrx));
		ncy = (nry > N_ONE) ? N_ONEW : ((nry < -N_ONE) ? -N_ONEW : NW'(nry));
		// centre on the box: fall back to the box x-axis
		tcx = ((TW+1)'(dv_s10.c) + HALF_T) >>> (FR - cobb_pkg::NORM_FRAC);
		tcy = ((TW+1)'(dv_s10.s) + HALF_T) >>> (FR - cobb_pkg::NORM_FRAC);
		nfx = dv_s10.d2zero ? NW'(tcx) : ncx;
		nfy = dv_s10.d2zero ? NW'(tcy) : ncy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s9  <= v_d;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s9  <= dv_d;
			ux_s9  <= dv_d.negx ? -$signed(TW'(qx_d)) : $signed(TW'(qx_d));
			uy_s9  <= dv_d.negy ? -$signed(TW'(qy_d)) : $signed(TW'(qy_d));

			dv_s10  <= dv_s9;
			nxc_s10 <= ux_s9 * dv_s9.c;
			nys_s10 <= uy_s9 * dv_s9.s;
			nxs_s10 <= ux_s9 * dv_s9.s;
			nyc_s10 <= uy_s9 * dv_s9.c;

			res_s11.hit   <= dv_s10.hit;
			res_s11.depth <= dv_s10.hit ? (COORD_WIDTH-1)'(dv_s10.depth) : '0;
			res_s11.cx    <= dv_s10.hit ? COORD_WIDTH'($unsigned(dv_s10.wx)) : '0;
			res_s11.cy    <= dv_s10.hit ? COORD_WIDTH'($unsigned(dv_s10.wy)) : '0;
			res_s11.nx    <= dv_s10.hit ? nfx : '0;
			res_s11.ny    <= dv_s10.hit ? nfy : '0;
		end
	end

	// output register with a skid entry behind it
	res_t out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic take_p, out_free;

	assign en       = ~skid_v_q;
	assign take_p   = v_s11 & en;
	assign out_free = ~out_v_q | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q | take_p;
			skid_v_q <= 1'b0;
		end else if (take_p) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res_s11;
		end else if (take_p) begin
			skid_q <= res_s11;
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.hit       = out_q.hit;
	assign out_ch.depth     = out_q.depth;
	assign out_ch.contact_x = out_q.cx;
	assign out_ch.contact_y = out_q.cy;
	assign out_ch.normal_x  = out_q.nx;
	assign out_ch.normal_y  = out_q.ny;

	`COBB_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_v_q, out_v_q)
	`COBB_ASSERT_IMP(a_miss_is_zero, clk, arst_n, out_v_q && !out_q.hit, out_q.depth == '0 && out_q.nx == '0 && out_q.ny == '0 && out_q.cx == '0)
	`COBB_ASSERT_IMP(a_normal_bounded, clk, arst_n, out_v_q && out_q.hit, out_q.nx <= N_ONEW && out_q.nx >= -N_ONEW && out_q.ny <= N_ONEW && out_q.ny >= -N_ONEW)
	`COBB_ASSERT(a_stall_holds_tail, clk, arst_n, !en |=> $stable(v_s11))
endmodule

// ===== verif/cobb_checker.sv =====
// checker: predicts the contact result of each accepted item and compares it in order
`timescale 1ns / 100ps
module cobb_checker (
	input logic       clk,
	input logic       arst_n,
	cobb_in_if.sink   in_mon,
	cobb_out_if.sink  out_mon,
	output int        fail_count,
	output int        pending
);
	typedef struct packed {
		logic                hit;
		logic [30:0]         depth;
		logic signed [31:0]  contact_x;
		logic signed [31:0]  contact_y;
		logic signed [15:0]  normal_x;
		logic signed [15:0]  normal_y;
	} contact_t;

	localparam logic signed [63:0] ONE28 = 64'sd1 <<< 28;
	localparam logic signed [63:0] ONE30 = 64'sd1 <<< 30;

	contact_t expected_q[$];

	function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
		logic signed [63:0] bias;
		bias = 64'sd1 <<< (s - 1);
		return (v + bias) >>> s;
	endfunction

	function automatic logic signed [63:0] clamp(logic signed [63:0] v,
		logic signed [63:0] lo, logic signed [63:0] hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [63:0] root_nearest(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return (v > r) ? r + 1 : r;
	endfunction

	function automatic logic signed [63:0] div_nearest(logic signed [63:0] n,
		logic signed [63:0] d);
		logic signed [63:0] m, q;
		m = n < 0 ? -n : n;
		q = (m + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic void box_trig(input logic [15:0] ang, output logic signed [63:0] c,
		output logic signed [63:0] s);
		logic [31:0] u;
		logic [1:0] quad;
		logic signed [63:0] x, y, z, t;
		u = {ang, 16'h0} + 32'h2000_0000;
		quad = u[31:30];
		z = $signed({34'd0, u[29:0]}) - 64'sh2000_0000;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			logic signed [63:0] xs, ys;
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= $signed({32'd0, cobb_pkg::atan_turn(i)});
			end else begin
				x += ys; y -= xs; z += $signed({32'd0, cobb_pkg::atan_turn(i)});
			end
		end
		case (quad)
			2'd1: begin t = x; x = -y; y = t; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		x = clamp(x, -ONE30, ONE30);
		y = clamp(y, -ONE30, ONE30);
		c = clamp(round_shift(x, 2), -ONE28, ONE28);
		s = clamp(round_shift(y, 2), -ONE28, ONE28);
	endfunction

	function automatic contact_t predict_contact(logic signed [31:0] cx_i,
		logic signed [31:0] cy_i, logic [30:0] rad_i, logic signed [31:0] bx_i,
		logic signed [31:0] by_i, logic [30:0] w_i, logic [30:0] h_i, logic [15:0] ang);
		contact_t res;
		logic signed [63:0] cx, cy, rad, bx, by, hw, hh, c, s, ox, oy, lx, ly;
		logic signed [63:0] clx, cly, dx, dy, root_d, wx, wy, nx, ny, ux, uy;
		logic [63:0] d2;
		res = '0;
		cx = cx_i; cy = cy_i; bx = bx_i; by = by_i;
		rad = {33'd0, rad_i};
		hw = {33'd0, w_i} >>> 1;
		hh = {33'd0, h_i} >>> 1;
		box_trig(ang, c, s);
		ox = cx - bx;
		oy = cy - by;
		lx = round_shift(ox * c + oy * s, 28);
		ly = round_shift(oy * c - ox * s, 28);
		clx = clamp(lx, -hw, hw);
		cly = clamp(ly, -hh, hh);
		dx = lx - clx;
		dy = ly - cly;
		if (dx > rad || dx < -rad || dy > rad || dy < -rad) return res;
		d2 = dx * dx + dy * dy;
		if (d2 > rad * rad) return res;
		root_d = root_nearest(d2);
		wx = clamp(bx + round_shift(clx * c - cly * s, 28), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		wy = clamp(by + round_shift(clx * s + cly * c, 28), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		if (d2 == 0) begin
			// centre inside the box: fall back to the box x-axis
			nx = round_shift(c, 14);
			ny = round_shift(s, 14);
		end else begin
			ux = div_nearest(-dx * ONE28, root_d);
			uy = div_nearest(-dy * ONE28, root_d);
			nx = round_shift(ux * c - uy * s, 42);
			ny = round_shift(ux * s + uy * c, 42);
		end
		nx = clamp(nx, -cobb_pkg::NORM_ONE, cobb_pkg::NORM_ONE);
		ny = clamp(ny, -cobb_pkg::NORM_ONE, cobb_pkg::NORM_ONE);
		res.hit = 1'b1;
		res.depth = 31'(rad - root_d);
		res.contact_x = 32'(wx);
		res.contact_y = 32'(wy);
		res.normal_x = 16'(nx);
		res.normal_y = 16'(ny);
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				expected_q = {expected_q, predict_contact(in_mon.circle_x, in_mon.circle_y,
					in_mon.circle_radius, in_mon.box_x, in_mon.box_y, in_mon.box_width,
					in_mon.box_height, in_mon.box_angle)};
			if (out_mon.valid && out_mon.ready) begin
				contact_t got, want;
				got = '{out_mon.hit, out_mon.depth, out_mon.contact_x, out_mon.contact_y,
					out_mon.normal_x, out_mon.normal_y};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb_circle_obb_collision.sv =====
// testbench top: drives circle/box items with random gaps and gives the verdict
`timescale 1ns / 100ps
module tb_circle_obb_collision;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	bit quiet;

	cobb_in_if in_ch ();
	cobb_out_if out_ch ();

	circle_obb_collision dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));
	cobb_checker chk (.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.circle_x, in_ch.circle_y, in_ch.circle_radius, in_ch.box_x, in_ch.box_y,
			in_ch.box_width, in_ch.box_height, in_ch.box_angle} = '0;
		out_ch.ready = 1'b0;
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_pair(logic [31:0] cx, logic [31:0] cy, logic [30:0] r,
		logic [31:0] bx, logic [31:0] by, logic [30:0] w, logic [30:0] h, logic [15:0] a);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.circle_x <= cx; in_ch.circle_y <= cy; in_ch.circle_radius <= r;
		in_ch.box_x <= bx; in_ch.box_y <= by; in_ch.box_width <= w;
		in_ch.box_height <= h; in_ch.box_angle <= a;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] base, int span);
		return base + 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	initial begin
		logic [31:0] bx, by;
		logic [30:0] w, h;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// extremes, centre inside, touching, miss, saturated contact, quadrants
		send_pair(0, 0, 31'h10000, 0, 0, 31'h40000, 31'h20000, 0);
		send_pair(32'h30000, 0, 31'h10000, 0, 0, 31'h40000, 31'h40000, 0);
		send_pair(32'h50000, 0, 31'h10000, 0, 0, 31'h40000, 31'h40000, 0);
		send_pair(32'h30000, 32'h30000, 31'h20000, 0, 0, 31'h40000, 31'h40000, 16'h2000);
		send_pair(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 16'hffff);
		send_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h80000000,
			31'h7fffffff, 31'h7fffffff, 16'h8000);
		send_pair(32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h80000000,
			0, 0, 16'h4000);
		send_pair(32'h7fffffff, 0, 31'h7fffffff, 32'h80000000, 0, 31'h7fffffff, 0, 16'hc000);
		send_pair(32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0, 0, 16'h1234);
		send_pair(0, 32'h20000, 31'h8000, 0, 0, 31'h20000, 31'h20000, 16'h6000);
		for (int a = 0; a < 8; a++)
			send_pair(32'h18000, 32'h8000, 31'h18000, 0, 0, 31'h20001, 31'h10001,
				16'(a * 16'h2000 + 16'h0800));
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		for (int i = 0; i < 950; i++) begin
			if (i == 850) quiet = 1'b1;
			if ($urandom_range(0, 9) < 8) begin
				// close pairs so hits are common
				bx = $urandom; by = $urandom;
				w = 31'($urandom_range(0, 31'h80000));
				h = 31'($urandom_range(0, 31'h80000));
				send_pair(near_coord(bx, 32'h60000), near_coord(by, 32'h60000),
					31'($urandom_range(0, 31'h40000)), bx, by, w, h, 16'($urandom));
			end else begin
				send_pair($urandom, $urandom, 31'($urandom), $urandom, $urandom,
					31'($urandom), 31'($urandom), 16'($urandom));
			end
		end
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end
endmodule
